>>> design/idfp_pkg.sv
// ----------------------------------------------------------------------------
// idfp_pkg
// Types, character codes and month lookup for the internet date field parser.
// ----------------------------------------------------------------------------
package idfp_pkg;

  typedef enum logic [4:0] {
    PH_LEAD,
    PH_COMMENT,
    PH_LEAD2,
    PH_WDAY,
    PH_WSKIP1,
    PH_WSKIP2,
    PH_DAY,
    PH_MON1,
    PH_MON2,
    PH_MON3,
    PH_MONSKIP,
    PH_MONBLANK,
    PH_YEAR,
    PH_YEARJUNK,
    PH_YEARBLANK,
    PH_HOUR,
    PH_MIN,
    PH_SEC,
    PH_ZBLANK,
    PH_ZGMT,
    PH_ZNUM,
    PH_ZNAMED,
    PH_DONE_GMT,
    PH_DONE_NUM
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_NAMED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ZK_GMT   = 2'd0,
    ZK_NUM   = 2'd1,
    ZK_NAMED = 2'd2
  } zkind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_G   = 8'h47;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_M   = 8'h4D;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  localparam logic [3:0]  MON_JAN  = 4'd0;
  localparam logic [3:0]  MON_MAR  = 4'd2;
  localparam logic [3:0]  MON_MAY  = 4'd4;
  localparam logic [3:0]  MON_JUN  = 4'd5;
  localparam logic [3:0]  MON_JUL  = 4'd6;
  localparam logic [3:0]  MON_NONE = 4'd12;

  localparam logic [13:0] YEAR_BASE = 14'd1900;
  localparam logic [17:0] YEAR_SAT  = 18'd16383;

  function automatic logic [3:0] month_code(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] m;
    unique case ({a, b})
      16'h4A61: m = 4'd0;
      16'h4665: m = 4'd1;
      16'h4D61: m = 4'd2;
      16'h4170: m = 4'd3;
      16'h4A75: m = 4'd5;
      16'h4175: m = 4'd7;
      16'h5365: m = 4'd8;
      16'h4F63: m = 4'd9;
      16'h4E6F: m = 4'd10;
      16'h4465: m = 4'd11;
      default:  m = MON_NONE;
    endcase
    return m;
  endfunction

endpackage

>>> design/idfp_if.sv
// ----------------------------------------------------------------------------
// idfp channel interfaces
// Valid/ready channels for input bytes and parsed date results.
// ----------------------------------------------------------------------------
interface idfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface idfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [6:0]         day;
  logic [3:0]         month;
  logic [13:0]        year;
  logic [6:0]         hour;
  logic [6:0]         minute;
  logic [6:0]         second;
  logic signed [13:0] zone_minutes;
  logic [1:0]         zone_kind;

  modport source (output valid, output status, output day, output month, output year,
                  output hour, output minute, output second, output zone_minutes,
                  output zone_kind, input ready);
  modport sink   (input valid, input status, input day, input month, input year,
                  input hour, input minute, input second, input zone_minutes,
                  input zone_kind, output ready);
endinterface

>>> design/internet_date_field_parser.sv
// ----------------------------------------------------------------------------
// internet_date_field_parser
// Byte-serial parser for internet style date headers. One result per string.
// Flow: a byte is registered at transfer, then updates the parse state;
//   the closing byte's result is then captured in the result register.
// Throughput: one byte per cycle in a single pass unless a result stalls.
// Reset: synchronous, active low; clears parse state and both valid flags.
// ----------------------------------------------------------------------------
module internet_date_field_parser #(
  parameter int MAX_YEAR_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  idfp_in_if.sink    in_chan,
  idfp_out_if.source out_chan
);

  localparam int DCW = $clog2(MAX_YEAR_DIGITS + 2);
  localparam logic [DCW-1:0] CNT_MAX = DCW'(MAX_YEAR_DIGITS);

  logic       s1_v_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  idfp_pkg::phase_t phase_r, phase_nxt;
  logic [13:0]    acc_r, acc_nxt;
  logic [DCW-1:0] cnt_r, cnt_nxt;
  logic [7:0]     mfirst_r, mfirst_nxt;
  logic           zsign_r, zsign_nxt;
  logic           err_r, err_nxt;
  logic [6:0]     day_r, day_nxt;
  logic [3:0]     mon_r, mon_nxt;
  logic [13:0]    year_r, year_nxt;
  logic [6:0]     hour_r, hour_nxt;
  logic [6:0]     min_r, min_nxt;
  logic [6:0]     sec_r, sec_nxt;
  logic [12:0]    zone_r, zone_nxt;

  logic                out_v_r;
  idfp_pkg::status_t   res_status;
  idfp_pkg::zkind_t    res_kind;
  logic signed [13:0]  res_zone;
  logic [13:0]         zmag;

  logic       emit;
  logic       adv;
  logic [7:0] c;
  logic [3:0] dig;
  logic       is_blank;
  logic       is_digit;

  idfp_pkg::phase_t ph1;
  logic [DCW-1:0] cnt1;
  logic [13:0]    acc1;
  logic [3:0]     mon1;
  logic [17:0]    year_mac;
  logic [13:0]    zone_w;
  logic [13:0]    zone_sum;
  logic [3:0]     mcode;
  logic [7:0]     c_lower;

  assign c        = s1_char_r;
  assign dig      = c[3:0];
  assign is_blank = (c == idfp_pkg::CH_SP) || (c == idfp_pkg::CH_TAB)
                 || (c == idfp_pkg::CH_LF);
  assign is_digit = (c >= idfp_pkg::CH_ZERO) && (c <= idfp_pkg::CH_NINE);
  assign c_lower  = ((c >= idfp_pkg::CH_UP_A) && (c <= idfp_pkg::CH_UP_Z))
                  ? c + idfp_pkg::CASE_DIFF : c;
  assign mcode    = idfp_pkg::month_code(mfirst_r, c_lower);

  assign emit = (c == idfp_pkg::CH_NUL) || s1_last_r;
  assign adv  = s1_v_r && (!emit || !out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      s1_char_r <= in_chan.char_in;
      s1_last_r <= in_chan.last_char;
    end
  end

  // resolve phases that fall through to another on the same byte
  always_comb begin
    ph1  = phase_r;
    cnt1 = cnt_r;
    acc1 = acc_r;
    mon1 = mon_r;
    unique case (phase_r)
      idfp_pkg::PH_LEAD, idfp_pkg::PH_LEAD2: begin
        if (!is_blank && !(c == idfp_pkg::CH_LPAREN && phase_r == idfp_pkg::PH_LEAD)) begin
          ph1 = is_digit ? idfp_pkg::PH_DAY : idfp_pkg::PH_WDAY;
        end
      end
      idfp_pkg::PH_WSKIP2: begin
        if (!is_blank) begin
          ph1 = idfp_pkg::PH_DAY;
        end
      end
      idfp_pkg::PH_MON3: begin
        if (mfirst_r == idfp_pkg::CH_UP_M) begin
          mon1 = (c_lower == idfp_pkg::CH_LO_R) ? idfp_pkg::MON_MAR : idfp_pkg::MON_MAY;
        end else begin
          mon1 = (c_lower == idfp_pkg::CH_LO_L) ? idfp_pkg::MON_JUL : idfp_pkg::MON_JUN;
        end
        ph1 = idfp_pkg::PH_MONSKIP;
      end
      idfp_pkg::PH_MONBLANK: begin
        if (!is_blank && c != idfp_pkg::CH_PLUS && c != idfp_pkg::CH_MINUS) begin
          ph1  = idfp_pkg::PH_YEAR;
          cnt1 = '0;
          acc1 = '0;
        end
      end
      idfp_pkg::PH_YEARBLANK: begin
        if (!is_blank) begin
          ph1  = idfp_pkg::PH_HOUR;
          cnt1 = '0;
        end
      end
      idfp_pkg::PH_ZBLANK: begin
        if (is_digit) begin
          ph1  = idfp_pkg::PH_ZNUM;
          cnt1 = '0;
          acc1 = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign year_mac = 18'(acc1) * 18'd10 + 18'(dig);

  always_comb begin
    unique case (cnt1)
      DCW'(0): zone_w = 14'd600;
      DCW'(1): zone_w = 14'd60;
      DCW'(2): zone_w = 14'd10;
      default: zone_w = 14'd1;
    endcase
  end

  assign zone_sum = acc1 + 14'(dig) * zone_w;

  // per-byte state update
  always_comb begin
    phase_nxt  = ph1;
    acc_nxt    = acc1;
    cnt_nxt    = cnt1;
    mfirst_nxt = mfirst_r;
    zsign_nxt  = zsign_r;
    err_nxt    = err_r;
    day_nxt    = day_r;
    mon_nxt    = mon1;
    year_nxt   = year_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    zone_nxt   = zone_r;

    if (err_r || c == idfp_pkg::CH_NUL) begin
      phase_nxt = phase_r;
      acc_nxt   = acc_r;
      cnt_nxt   = cnt_r;
      mon_nxt   = mon_r;
    end else begin
      unique case (ph1)
        idfp_pkg::PH_LEAD, idfp_pkg::PH_LEAD2: begin
          if (c == idfp_pkg::CH_LPAREN) begin
            phase_nxt = idfp_pkg::PH_COMMENT;
          end
        end
        idfp_pkg::PH_COMMENT: begin
          if (c == idfp_pkg::CH_RPAREN) begin
            phase_nxt = idfp_pkg::PH_LEAD2;
          end
        end
        idfp_pkg::PH_WDAY: begin
          if (c == idfp_pkg::CH_COMMA) begin
            phase_nxt = idfp_pkg::PH_WSKIP1;
          end else if (is_blank) begin
            err_nxt = 1'b1;
          end
        end
        idfp_pkg::PH_WSKIP1: begin
          if (is_blank) begin
            phase_nxt = idfp_pkg::PH_WSKIP2;
          end
        end
        idfp_pkg::PH_WSKIP2: begin
        end
        idfp_pkg::PH_DAY: begin
          if (is_digit && cnt1 < DCW'(2)) begin
            day_nxt = day_r * 7'd10 + 7'(dig);
            cnt_nxt = cnt1 + DCW'(1);
          end else if (cnt1 == '0) begin
            err_nxt = 1'b1;
          end else if (c == idfp_pkg::CH_COLON || is_blank) begin
            phase_nxt = idfp_pkg::PH_MON1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        idfp_pkg::PH_MON1: begin
          mfirst_nxt = ((c >= idfp_pkg::CH_LO_A) && (c <= idfp_pkg::CH_LO_Z))
                     ? c - idfp_pkg::CASE_DIFF : c;
          phase_nxt  = idfp_pkg::PH_MON2;
        end
        idfp_pkg::PH_MON2: begin
          if (mcode == idfp_pkg::MON_NONE) begin
            err_nxt = 1'b1;
          end else begin
            mon_nxt   = mcode;
            phase_nxt = (mcode == idfp_pkg::MON_MAR || mcode == idfp_pkg::MON_JUN)
                      ? idfp_pkg::PH_MON3 : idfp_pkg::PH_MONSKIP;
          end
        end
        idfp_pkg::PH_MON3: begin
        end
        idfp_pkg::PH_MONSKIP: begin
          if (is_blank) begin
            phase_nxt = idfp_pkg::PH_MONBLANK;
          end
        end
        idfp_pkg::PH_MONBLANK: begin
          if (c == idfp_pkg::CH_PLUS) begin
            phase_nxt = idfp_pkg::PH_YEAR;
            cnt_nxt   = '0;
            acc_nxt   = '0;
          end else if (c == idfp_pkg::CH_MINUS) begin
            err_nxt = 1'b1;
          end
        end
        idfp_pkg::PH_YEAR, idfp_pkg::PH_YEARJUNK: begin
          if (ph1 == idfp_pkg::PH_YEAR && is_digit) begin
            if (cnt1 <= CNT_MAX) begin
              cnt_nxt = cnt1 + DCW'(1);
            end
            acc_nxt = (year_mac > idfp_pkg::YEAR_SAT) ? 14'(idfp_pkg::YEAR_SAT)
                                                     : year_mac[13:0];
          end else if (!is_blank) begin
            phase_nxt = idfp_pkg::PH_YEARJUNK;
          end else if (acc1 == '0 || cnt1 > CNT_MAX) begin
            err_nxt = 1'b1;
          end else begin
            year_nxt  = (acc1 > idfp_pkg::YEAR_BASE) ? acc1 - idfp_pkg::YEAR_BASE : acc1;
            phase_nxt = idfp_pkg::PH_YEARBLANK;
          end
        end
        idfp_pkg::PH_YEARBLANK: begin
        end
        idfp_pkg::PH_HOUR: begin
          if (is_digit && cnt1 < DCW'(2)) begin
            hour_nxt = hour_r * 7'd10 + 7'(dig);
            cnt_nxt  = cnt1 + DCW'(1);
          end else if (cnt1 == '0) begin
            err_nxt = 1'b1;
          end else if (c == idfp_pkg::CH_COLON) begin
            phase_nxt = idfp_pkg::PH_MIN;
            cnt_nxt   = '0;
          end else begin
            err_nxt = 1'b1;
          end
        end
        idfp_pkg::PH_MIN: begin
          if (is_digit && cnt1 < DCW'(2)) begin
            min_nxt = min_r * 7'd10 + 7'(dig);
            cnt_nxt = cnt1 + DCW'(1);
          end else if (cnt1 == '0) begin
            err_nxt = 1'b1;
          end else if (c == idfp_pkg::CH_COLON) begin
            phase_nxt = idfp_pkg::PH_SEC;
            cnt_nxt   = '0;
          end else if (is_blank) begin
            phase_nxt = idfp_pkg::PH_ZBLANK;
          end else begin
            err_nxt = 1'b1;
          end
        end
        idfp_pkg::PH_SEC: begin
          if (is_digit && cnt1 < DCW'(2)) begin
            sec_nxt = sec_r * 7'd10 + 7'(dig);
            cnt_nxt = cnt1 + DCW'(1);
          end else if (cnt1 == '0) begin
            err_nxt = 1'b1;
          end else if (is_blank) begin
            phase_nxt = idfp_pkg::PH_ZBLANK;
          end else begin
            err_nxt = 1'b1;
          end
        end
        idfp_pkg::PH_ZBLANK: begin
          if (!is_blank) begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (c == idfp_pkg::CH_UP_G) begin
              phase_nxt = idfp_pkg::PH_ZGMT;
              cnt_nxt   = DCW'(1);
            end else if (c == idfp_pkg::CH_PLUS || c == idfp_pkg::CH_MINUS) begin
              zsign_nxt = (c == idfp_pkg::CH_MINUS);
              phase_nxt = idfp_pkg::PH_ZNUM;
            end else begin
              phase_nxt = idfp_pkg::PH_ZNAMED;
            end
          end
        end
        idfp_pkg::PH_ZGMT: begin
          if (is_blank) begin
            phase_nxt = (cnt1 == DCW'(3)) ? idfp_pkg::PH_DONE_GMT : idfp_pkg::PH_ZNAMED;
          end else if ((cnt1 == DCW'(1) && c == idfp_pkg::CH_UP_M)
                    || (cnt1 == DCW'(2) && c == idfp_pkg::CH_UP_T)) begin
            cnt_nxt = cnt1 + DCW'(1);
          end else begin
            phase_nxt = idfp_pkg::PH_ZNAMED;
          end
        end
        idfp_pkg::PH_ZNUM: begin
          if (!is_digit) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = zone_sum;
            cnt_nxt = cnt1 + DCW'(1);
            if (cnt1 >= DCW'(3)) begin
              zone_nxt  = zone_sum[12:0];
              phase_nxt = idfp_pkg::PH_DONE_NUM;
            end
          end
        end
        idfp_pkg::PH_ZNAMED, idfp_pkg::PH_DONE_GMT, idfp_pkg::PH_DONE_NUM: begin
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  // result from the state after this byte
  always_comb begin
    res_status = idfp_pkg::ST_SYNTAX;
    res_kind   = idfp_pkg::ZK_GMT;
    if (!err_nxt) begin
      priority if (phase_nxt == idfp_pkg::PH_DONE_GMT
                || (phase_nxt == idfp_pkg::PH_ZGMT && cnt_nxt == DCW'(3))) begin
        res_status = idfp_pkg::ST_OK;
        res_kind   = idfp_pkg::ZK_GMT;
      end else if (phase_nxt == idfp_pkg::PH_ZGMT || phase_nxt == idfp_pkg::PH_ZNAMED) begin
        res_status = idfp_pkg::ST_NAMED;
        res_kind   = idfp_pkg::ZK_NAMED;
      end else if (phase_nxt == idfp_pkg::PH_DONE_NUM) begin
        res_status = idfp_pkg::ST_OK;
        res_kind   = idfp_pkg::ZK_NUM;
      end else begin
        res_status = idfp_pkg::ST_SYNTAX;
      end
    end
  end

  assign zmag     = (res_kind == idfp_pkg::ZK_NUM) ? {1'b0, zone_nxt} : '0;
  assign res_zone = zsign_nxt ? -$signed(zmag) : $signed(zmag);

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n || (adv && emit)) begin
      phase_r  <= idfp_pkg::PH_LEAD;
      acc_r    <= '0;
      cnt_r    <= '0;
      mfirst_r <= '0;
      zsign_r  <= 1'b0;
      err_r    <= 1'b0;
      day_r    <= '0;
      mon_r    <= '0;
      year_r   <= '0;
      hour_r   <= '0;
      min_r    <= '0;
      sec_r    <= '0;
      zone_r   <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      mfirst_r <= mfirst_nxt;
      zsign_r  <= zsign_nxt;
      err_r    <= err_nxt;
      day_r    <= day_nxt;
      mon_r    <= mon_nxt;
      year_r   <= year_nxt;
      hour_r   <= hour_nxt;
      min_r    <= min_nxt;
      sec_r    <= sec_nxt;
      zone_r   <= zone_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && emit) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
    if (adv && emit) begin
      out_chan.status <= res_status;
      if (res_status == idfp_pkg::ST_SYNTAX) begin
        out_chan.day          <= '0;
        out_chan.month        <= '0;
        out_chan.year         <= '0;
        out_chan.hour         <= '0;
        out_chan.minute       <= '0;
        out_chan.second       <= '0;
        out_chan.zone_minutes <= '0;
        out_chan.zone_kind    <= '0;
      end else begin
        out_chan.day          <= day_nxt;
        out_chan.month        <= mon_nxt;
        out_chan.year         <= year_nxt;
        out_chan.hour         <= hour_nxt;
        out_chan.minute       <= min_nxt;
        out_chan.second       <= sec_nxt;
        out_chan.zone_minutes <= res_zone;
        out_chan.zone_kind    <= res_kind;
      end
    end
  end

  assign out_chan.valid = out_v_r;

  a_reset_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> (phase_r == idfp_pkg::PH_LEAD && !err_r && cnt_r == '0))
    else $error("parse state not cleared after result");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !(adv && emit)) |=> err_r)
    else $error("syntax error flag dropped mid string");

  a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_char_r) && $stable(s1_last_r)))
    else $error("pending byte overwritten");

  a_named_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_chan.status == idfp_pkg::ST_NAMED)
              == (out_chan.zone_kind == idfp_pkg::ZK_NAMED)))
    else $error("named zone status and kind disagree");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_chan.status == idfp_pkg::ST_SYNTAX)
      |-> (out_chan.day == '0 && out_chan.year == '0 && out_chan.zone_minutes == '0))
    else $error("error result carries field data");

endmodule

>>> bench/internet_date_field_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_date_field_parser_checker
// Watches both channels of the date field parser. Each non-NUL byte transfer runs
// through a byte-serial parse of its own; each string end queues the date it
// should produce, and every result transfer is compared field by field.
// ----------------------------------------------------------------------------
module internet_date_field_parser_checker #(
  parameter int YEAR_DIGITS_MAX = 4
) (
  input  logic clk,
  input  logic rst_n,
  idfp_in_if   in_mon,
  idfp_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  import idfp_pkg::*;

  localparam int unsigned YEAR_OFFSET = 1900;
  localparam int unsigned ACC_CEILING = 16383;

  typedef struct {
    status_t            status;
    logic [6:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic [6:0]         hour;
    logic [6:0]         minute;
    logic [6:0]         second;
    logic signed [13:0] zone_minutes;
    zkind_t             zone_kind;
  } date_fields_t;

  date_fields_t predicted_dates[$];

  phase_t      ph;
  int unsigned acc;
  int unsigned ndig;
  logic [7:0]  mon_lead;
  bit          neg_zone;
  bit          broken;
  int unsigned fld_day, fld_mon, fld_year, fld_hour, fld_min, fld_sec, fld_zone;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_state();
    ph       = PH_LEAD;
    acc      = 0;
    ndig     = 0;
    mon_lead = '0;
    neg_zone = 1'b0;
    broken   = 1'b0;
    fld_day  = 0;
    fld_mon  = 0;
    fld_year = 0;
    fld_hour = 0;
    fld_min  = 0;
    fld_sec  = 0;
    fld_zone = 0;
  endfunction

  // Returns 1 when c ends a one- or two-digit field and needs a terminator check.
  function automatic bit take_digit(input logic [7:0] c, inout int unsigned fld);
    if (is_digit(c) && ndig < 2) begin
      fld  = fld * 10 + (c - CH_ZERO);
      ndig = ndig + 1;
      return 1'b0;
    end
    if (ndig == 0) begin
      broken = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned month_of(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      "Ja":    return 0;
      "Fe":    return 1;
      "Ma":    return MON_MAR;
      "Ap":    return 3;
      "Ju":    return MON_JUN;
      "Au":    return 7;
      "Se":    return 8;
      "Oc":    return 9;
      "No":    return 10;
      "De":    return 11;
      default: return MON_NONE;
    endcase
  endfunction

  function automatic void consume_char(input logic [7:0] c);
    bit          again;
    logic [7:0]  low;
    int unsigned m;
    again = 1'b1;
    while (again && !broken) begin
      again = 1'b0;
      case (ph)
        PH_LEAD, PH_LEAD2: begin
          if (!is_blank(c)) begin
            if (c == CH_LPAREN && ph == PH_LEAD) begin
              ph = PH_COMMENT;
            end else begin
              ph    = is_digit(c) ? PH_DAY : PH_WDAY;
              again = 1'b1;
            end
          end
        end
        PH_COMMENT: if (c == CH_RPAREN) ph = PH_LEAD2;
        PH_WDAY: begin
          if (c == CH_COMMA) ph = PH_WSKIP1;
          else if (is_blank(c)) broken = 1'b1;
        end
        PH_WSKIP1: if (is_blank(c)) ph = PH_WSKIP2;
        PH_WSKIP2: begin
          if (!is_blank(c)) begin
            ph    = PH_DAY;
            again = 1'b1;
          end
        end
        PH_DAY: begin
          if (take_digit(c, fld_day)) begin
            if (c == CH_COLON || is_blank(c)) ph = PH_MON1;
            else broken = 1'b1;
          end
        end
        PH_MON1: begin
          mon_lead = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_DIFF : c;
          ph       = PH_MON2;
        end
        PH_MON2: begin
          low = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_DIFF : c;
          m   = month_of(mon_lead, low);
          if (m == MON_NONE) begin
            broken = 1'b1;
          end else begin
            fld_mon = m;
            ph      = (m == MON_MAR || m == MON_JUN) ? PH_MON3 : PH_MONSKIP;
          end
        end
        PH_MON3: begin
          if (mon_lead == CH_UP_M)
            fld_mon = (c == CH_LO_R || c == CH_UP_R) ? MON_MAR : MON_MAY;
          else
            fld_mon = (c == CH_LO_L || c == CH_UP_L) ? MON_JUL : MON_JUN;
          ph    = PH_MONSKIP;
          again = 1'b1;
        end
        PH_MONSKIP: if (is_blank(c)) ph = PH_MONBLANK;
        PH_MONBLANK: begin
          if (!is_blank(c)) begin
            ph   = PH_YEAR;
            ndig = 0;
            acc  = 0;
            if (c == CH_MINUS) broken = 1'b1;
            else if (c != CH_PLUS) again = 1'b1;
          end
        end
        PH_YEAR: begin
          if (is_digit(c)) begin
            if (ndig < 15) ndig = ndig + 1;
            acc = acc * 10 + (c - CH_ZERO);
            if (acc > ACC_CEILING) acc = ACC_CEILING;
          end else begin
            ph    = PH_YEARJUNK;
            again = 1'b1;
          end
        end
        PH_YEARJUNK: begin
          if (is_blank(c)) begin
            if (acc == 0 || ndig > YEAR_DIGITS_MAX) begin
              broken = 1'b1;
            end else begin
              fld_year = (acc > YEAR_OFFSET) ? acc - YEAR_OFFSET : acc;
              ph       = PH_YEARBLANK;
            end
          end
        end
        PH_YEARBLANK: begin
          if (!is_blank(c)) begin
            ph    = PH_HOUR;
            ndig  = 0;
            again = 1'b1;
          end
        end
        PH_HOUR: begin
          if (take_digit(c, fld_hour)) begin
            if (c == CH_COLON) begin
              ph   = PH_MIN;
              ndig = 0;
            end else begin
              broken = 1'b1;
            end
          end
        end
        PH_MIN: begin
          if (take_digit(c, fld_min)) begin
            if (c == CH_COLON) begin
              ph   = PH_SEC;
              ndig = 0;
            end else if (is_blank(c)) begin
              ph = PH_ZBLANK;
            end else begin
              broken = 1'b1;
            end
          end
        end
        PH_SEC: begin
          if (take_digit(c, fld_sec)) begin
            if (is_blank(c)) ph = PH_ZBLANK;
            else broken = 1'b1;
          end
        end
        PH_ZBLANK: begin
          if (!is_blank(c)) begin
            acc  = 0;
            ndig = 0;
            if (c == CH_UP_G) begin
              ph   = PH_ZGMT;
              ndig = 1;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              neg_zone = (c == CH_MINUS);
              ph       = PH_ZNUM;
            end else if (is_digit(c)) begin
              ph    = PH_ZNUM;
              again = 1'b1;
            end else begin
              ph = PH_ZNAMED;
            end
          end
        end
        PH_ZGMT: begin
          if (is_blank(c))
            ph = (ndig == 3) ? PH_DONE_GMT : PH_ZNAMED;
          else if ((ndig == 1 && c == CH_UP_M) || (ndig == 2 && c == CH_UP_T))
            ndig = ndig + 1;
          else
            ph = PH_ZNAMED;
        end
        PH_ZNUM: begin
          if (!is_digit(c)) begin
            broken = 1'b1;
          end else begin
            acc  = acc * 10 + (c - CH_ZERO);
            ndig = ndig + 1;
            if (ndig >= 4) begin
              fld_zone = (acc / 100) * 60 + acc % 100;
              ph       = PH_DONE_NUM;
            end
          end
        end
        PH_ZNAMED, PH_DONE_GMT, PH_DONE_NUM: ;
        default: broken = 1'b1;
      endcase
    end
  endfunction

  function automatic date_fields_t close_string();
    date_fields_t r;
    status_t      st;
    zkind_t       zk;
    st = ST_SYNTAX;
    zk = ZK_GMT;
    if (!broken) begin
      if (ph == PH_DONE_GMT || (ph == PH_ZGMT && ndig == 3)) begin
        st = ST_OK;
        zk = ZK_GMT;
      end else if (ph == PH_ZGMT || ph == PH_ZNAMED) begin
        st = ST_NAMED;
        zk = ZK_NAMED;
      end else if (ph == PH_DONE_NUM) begin
        st = ST_OK;
        zk = ZK_NUM;
      end
    end
    r.status       = st;
    r.day          = '0;
    r.month        = '0;
    r.year         = '0;
    r.hour         = '0;
    r.minute       = '0;
    r.second       = '0;
    r.zone_minutes = '0;
    r.zone_kind    = ZK_GMT;
    if (st != ST_SYNTAX) begin
      r.day       = 7'(fld_day);
      r.month     = 4'(fld_mon);
      r.year      = 14'(fld_year);
      r.hour      = 7'(fld_hour);
      r.minute    = 7'(fld_min);
      r.second    = 7'(fld_sec);
      r.zone_kind = zk;
      if (zk == ZK_NUM) begin
        r.zone_minutes = 14'(fld_zone);
        if (neg_zone) r.zone_minutes = -r.zone_minutes;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    date_fields_t want;
    if (!rst_n) begin
      clear_state();
      predicted_dates.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.char_in != CH_NUL) consume_char(in_mon.char_in);
        if (in_mon.char_in == CH_NUL || in_mon.last_char) begin
          predicted_dates.push_back(close_string());
          clear_state();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_dates.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = predicted_dates.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch("status", out_mon.status, want.status);
          if (out_mon.day !== want.day)
            report_mismatch("day", out_mon.day, want.day);
          if (out_mon.month !== want.month)
            report_mismatch("month", out_mon.month, want.month);
          if (out_mon.year !== want.year)
            report_mismatch("year", out_mon.year, want.year);
          if (out_mon.hour !== want.hour)
            report_mismatch("hour", out_mon.hour, want.hour);
          if (out_mon.minute !== want.minute)
            report_mismatch("minute", out_mon.minute, want.minute);
          if (out_mon.second !== want.second)
            report_mismatch("second", out_mon.second, want.second);
          if (out_mon.zone_minutes !== want.zone_minutes)
            report_mismatch("zone_minutes", out_mon.zone_minutes, want.zone_minutes);
          if (out_mon.zone_kind !== want.zone_kind)
            report_mismatch("zone_kind", out_mon.zone_kind, want.zone_kind);
        end
      end
    end
    pending <= predicted_dates.size();
  end

endmodule

>>> bench/internet_date_field_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_date_field_parser_tb
// Streams date header strings into the parser: a directed set of corner
// strings, then random dates with odd fields, damaged dates and byte noise, with
// random gaps and stalls and one long result hold-off. The checker beside the
// block predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module internet_date_field_parser_tb;
  import idfp_pkg::*;

  localparam int YEAR_DIGITS = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTE_TARGET = 1700;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 20;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   sent_bytes = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;

  logic [7:0] text_q[$];

  string month_names[12] = '{"january", "february", "march", "april", "may", "june",
                             "july", "august", "september", "october", "november",
                             "december"};
  string weekday_names[7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
  string zone_names[8] = '{"EST", "PDT", "UT", "Z", "G", "GM", "GMTx", "gmt"};

  idfp_in_if  in_chan ();
  idfp_out_if out_chan ();

  internet_date_field_parser #(.MAX_YEAR_DIGITS(YEAR_DIGITS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  internet_date_field_parser_checker #(.YEAR_DIGITS_MAX(YEAR_DIGITS)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold one byte until its transfer, then maybe drop valid for a burst
  task automatic send_byte(input logic [7:0] c, input logic fin, input bit gappy);
    in_chan.valid     <= 1'b1;
    in_chan.char_in   <= c;
    in_chan.last_char <= fin;
    do @(posedge clk); while (!in_chan.ready);
    sent_bytes++;
    if (gappy && !calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic flush_text(input bit nul_end, input bit nul_last);
    int i;
    bit gappy;
    gappy = ($urandom_range(0, 2) != 0);
    for (i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], !nul_end && i == text_q.size() - 1, gappy);
    if (nul_end) send_byte(CH_NUL, nul_last, gappy);
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) &&
        $urandom_range(0, 1) == 1)
      return c ^ CASE_DIFF;
    return c;
  endfunction

  task automatic add_cased(input string s, input int len);
    int i;
    for (i = 0; i < len; i++) text_q.push_back(flip_case(s[i]));
  endtask

  task automatic add_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(CH_TAB);
        1:       text_q.push_back(CH_LF);
        default: text_q.push_back(CH_SP);
      endcase
    end
  endtask

  task automatic add_number(input int unsigned v, input int width);
    int p;
    p = text_q.size();
    repeat (width) begin
      text_q.insert(p, 8'(CH_ZERO + v % 10));
      v = v / 10;
    end
  endtask

  task automatic add_random_digits(input int width);
    int unsigned lim;
    lim = 1;
    repeat (width) lim = lim * 10;
    add_number($urandom_range(0, lim - 1), width);
  endtask

  task automatic add_short_field();
    add_random_digits($urandom_range(0, 3) == 0 ? 1 : 2);
  endtask

  task automatic build_date();
    int    m;
    int    width;
    int    k;
    string name;
    add_blanks(0, 2);
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(CH_LPAREN);
      repeat ($urandom_range(0, 5)) begin
        k = $urandom_range(1, 255);
        text_q.push_back(k == CH_RPAREN ? CH_UP_A : 8'(k));
      end
      text_q.push_back(CH_RPAREN);
      add_blanks(0, 2);
    end
    if ($urandom_range(0, 1) == 1) begin
      add_cased(weekday_names[$urandom_range(0, 6)], 3);
      text_q.push_back(CH_COMMA);
      repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      add_blanks(1, 2);
    end
    add_short_field();
    text_q.push_back($urandom_range(0, 3) == 0 ? CH_COLON : CH_SP);
    m    = $urandom_range(0, 11);
    name = month_names[m];
    add_cased(name, $urandom_range(3, name.len()));
    add_blanks(1, 2);
    if ($urandom_range(0, 7) == 0) text_q.push_back(CH_PLUS);
    case ($urandom_range(0, 15))
      0:       width = 1;
      1:       width = 5;
      2:       width = 3;
      3, 4, 5: width = 2;
      default: width = 4;
    endcase
    add_random_digits(width);
    if ($urandom_range(0, 7) == 0) text_q.push_back(8'($urandom_range(CH_LO_A, CH_LO_Z)));
    add_blanks(1, 2);
    add_short_field();
    text_q.push_back(CH_COLON);
    add_short_field();
    if ($urandom_range(0, 1) == 1) begin
      text_q.push_back(CH_COLON);
      add_short_field();
    end
    add_blanks(1, 2);
    case ($urandom_range(0, 5))
      0, 1: add_str("GMT");
      2:    add_str(zone_names[$urandom_range(0, 7)]);
      default: begin
        case ($urandom_range(0, 2))
          0: text_q.push_back(CH_PLUS);
          1: text_q.push_back(CH_MINUS);
          default: ;
        endcase
        add_random_digits(4);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      add_blanks(0, 1);
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
    end
    // damage some strings: overwrite one byte or cut the tail
    case ($urandom_range(0, 9))
      0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        k = $urandom_range(1, text_q.size() - 1);
        while (text_q.size() > k) text_q.delete(text_q.size() - 1);
      end
      default: ;
    endcase
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // result side: random stall bursts, and one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.char_in   <= CH_NUL;
    in_chan.last_char <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_str("Mon, 02 Jan 1995 10:20:30 GMT");                flush_text(1'b0, 1'b0);
    add_str("(note) 1:feB 99 1:2 +0530");                    flush_text(1'b0, 1'b0);
    add_str(" \t\nWed,x 31 DECEMBER +2000 23:59:59 -9959 tz"); flush_text(1'b1, 1'b0);
    add_str("7 Mar 12345 1:1 GMT");                          flush_text(1'b0, 1'b0);
    add_str("7 mAy 0 1:1 GMT");                              flush_text(1'b1, 1'b1);
    add_str("7 Jun -5 1:1 GMT");                             flush_text(1'b0, 1'b0);
    add_str("7 Jul 1900 1:1 EST");                           flush_text(1'b0, 1'b0);
    add_str("7 Apr 1901x 1:1 G");                            flush_text(1'b0, 1'b0);
    add_str("(open comment 9 Oct 99 1:1 GMT");               flush_text(1'b0, 1'b0);
    add_str("(a)(b) 9 Nov 99 1:1 GMT");                      flush_text(1'b0, 1'b0);
    add_str("12 Aug 2001 12:00:00");                         flush_text(1'b0, 1'b0);
    add_str("Tue 3 Sep 01 1:1 GMT");                         flush_text(1'b0, 1'b0);
    flush_text(1'b1, 1'b1);
    add_str("5 Feb 77 0:0:0 GMTx");                          flush_text(1'b0, 1'b0);
    add_str("5 Feb 77 0:0 GM");                              flush_text(1'b1, 1'b0);
    add_str("5 Feb 77 99:99:99 0000");                       flush_text(1'b0, 1'b0);
    add_str("5 Feb 77 1:1 +05x");                            flush_text(1'b0, 1'b0);
    add_str("5 Sep 77 1:1 -1234567");                        flush_text(1'b0, 1'b0);
    add_str("5 Xyz 77 1:1 GMT");                             flush_text(1'b0, 1'b0);
    add_str("123 Jan 77 1:1 GMT");                           flush_text(1'b0, 1'b0);
    add_str("5-Jan 77 1:1 GMT");                             flush_text(1'b0, 1'b0);

    hold_req = 1'b1;
    while (sent_bytes < BYTE_TARGET) begin
      if (sent_bytes > BYTE_TARGET * 4 / 5) calm = 1'b1;
      if ($urandom_range(0, 4) == 0) build_noise();
      else build_date();
      flush_text($urandom_range(0, 3) == 0, $urandom_range(0, 1));
    end
    in_chan.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
design/idfp_pkg.sv
design/idfp_if.sv
design/internet_date_field_parser.sv
bench/internet_date_field_parser_checker.sv
bench/internet_date_field_parser_tb.sv
